[hw/rtl/rgb2hsv_pkg.sv]
package rgb2hsv_pkg;

    localparam int CHANNEL_BITS = 12;
    localparam int HUE_BITS     = 16;

    // one quotient bit per divider stage; both divisions share the stages
    localparam int DIV_STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    // hue divisor is 6*delta, below 2^(CHANNEL_BITS+3)
    localparam int HDIV_BITS = CHANNEL_BITS + 3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

endpackage

[hw/rtl/rgb_to_hsv_converter_unit.sv]
// channel | dir | handshake                 | payload
// pixel   | in  | pixel_valid / pixel_ready | rgb2hsv_pkg::pixel_t (red, green, blue)
// hsv     | out | hsv_valid / hsv_ready     | rgb2hsv_pkg::hsv_t (hue, saturation, brightness)
//
// One pixel per cycle while no held result stalls the pipeline.
// Stage 1 finds max/min and the sector, stage 2 forms delta and both dividends,
// then DIV_STEPS restoring-divider stages retire one hue bit each, and the first CHANNEL_BITS one saturation bit each.
// Reset clears the valid bits only.
// A held result stalls the whole pipeline; pixel_ready drops only then.
module rgb_to_hsv_converter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  rgb2hsv_pkg::pixel_t pixel,
    output logic                hsv_valid,
    input  logic                hsv_ready,
    output rgb2hsv_pkg::hsv_t   hsv
);

    import rgb2hsv_pkg::*;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hi;
        logic [CHANNEL_BITS-1:0] lo;
        max_sel_t                sel;
        logic                    g_lt_b;
        logic [CHANNEL_BITS:0]   diff;   // two's complement
    } front_t;

    typedef struct packed {
        logic [HDIV_BITS-1:0]    h_rem;
        logic [HDIV_BITS-1:0]    h_div;
        logic [HUE_BITS-1:0]     h_quo;
        logic [CHANNEL_BITS-1:0] s_rem;
        logic [CHANNEL_BITS-1:0] s_div;
        logic [CHANNEL_BITS-1:0] s_low;
        logic [CHANNEL_BITS-1:0] s_quo;
        logic [CHANNEL_BITS-1:0] bright;
    } div_t;

    logic   advance;
    logic   front_valid_reg;
    front_t front_reg;
    front_t front_next;
    div_t   div_first_next;
    logic   div_valid_reg [0:DIV_STEPS];
    div_t   div_reg       [0:DIV_STEPS];
    div_t   div_next      [1:DIV_STEPS];

    assign advance     = !div_valid_reg[DIV_STEPS] || hsv_ready;
    assign pixel_ready = advance;

    // stage 1: max, min, sector and channel difference
    always_comb
    begin
        logic red_max;
        logic green_max;
        red_max   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
        green_max = !red_max && (pixel.green >= pixel.blue);

        if (red_max)
            front_next.sel = MAX_RED;
        else if (green_max)
            front_next.sel = MAX_GREEN;
        else
            front_next.sel = MAX_BLUE;

        case (front_next.sel)
            MAX_RED:
            begin
                front_next.hi   = pixel.red;
                front_next.diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
            end
            MAX_GREEN:
            begin
                front_next.hi   = pixel.green;
                front_next.diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
            end
            default:
            begin
                front_next.hi   = pixel.blue;
                front_next.diff = {1'b0, pixel.red} - {1'b0, pixel.green};
            end
        endcase

        front_next.lo = pixel.red;
        if (pixel.green < front_next.lo)
            front_next.lo = pixel.green;
        if (pixel.blue < front_next.lo)
            front_next.lo = pixel.blue;

        front_next.g_lt_b = pixel.green < pixel.blue;
    end

    // stage 2: delta, hue numerator/divisor, saturation dividend
    always_comb
    begin
        logic [CHANNEL_BITS-1:0]   delta;
        logic [HDIV_BITS-1:0]      d_ext;
        logic [HDIV_BITS-1:0]      d6;
        logic [HDIV_BITS-1:0]      base;
        logic [HDIV_BITS-1:0]      num;
        logic [2*CHANNEL_BITS-1:0] sat_dividend;

        delta = front_reg.hi - front_reg.lo;
        d_ext = {3'b000, delta};
        d6    = (d_ext << 2) + (d_ext << 1);

        case (front_reg.sel)
            MAX_RED:   base = front_reg.g_lt_b ? d6 : '0;
            MAX_GREEN: base = d_ext << 1;
            default:   base = d_ext << 2;
        endcase
        num = base + {{2{front_reg.diff[CHANNEL_BITS]}}, front_reg.diff};

        // gray: numerator 0 over divisor 1 yields hue 0
        if (delta == '0)
        begin
            div_first_next.h_rem = '0;
            div_first_next.h_div = HDIV_BITS'(1);
        end
        else
        begin
            div_first_next.h_rem = num;
            div_first_next.h_div = d6;
        end
        div_first_next.h_quo = '0;

        // delta * (2^N - 1); the high half is already below max
        sat_dividend = {delta, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, delta};
        div_first_next.s_rem  = sat_dividend[2*CHANNEL_BITS-1:CHANNEL_BITS];
        div_first_next.s_low  = sat_dividend[CHANNEL_BITS-1:0];
        // black: dividend is 0, divisor 1 yields saturation 0
        div_first_next.s_div  = (front_reg.hi == '0) ? CHANNEL_BITS'(1) : front_reg.hi;
        div_first_next.s_quo  = '0;
        div_first_next.bright = front_reg.hi;
    end

    // restoring divider stages
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_comb
        begin
            logic [HDIV_BITS:0]    h_shift;
            logic [HDIV_BITS:0]    h_sub;
            logic                  h_ge;
            logic [CHANNEL_BITS:0] s_shift;
            logic [CHANNEL_BITS:0] s_sub;
            logic                  s_ge;

            div_next[k+1] = div_reg[k];

            h_shift = {div_reg[k].h_rem, 1'b0};
            h_sub   = h_shift - {1'b0, div_reg[k].h_div};
            h_ge    = h_shift >= {1'b0, div_reg[k].h_div};
            if (k < HUE_BITS)
            begin
                div_next[k+1].h_rem = h_ge ? h_sub[HDIV_BITS-1:0] : h_shift[HDIV_BITS-1:0];
                div_next[k+1].h_quo = {div_reg[k].h_quo[HUE_BITS-2:0], h_ge};
            end

            s_shift = {div_reg[k].s_rem, div_reg[k].s_low[CHANNEL_BITS-1]};
            s_sub   = s_shift - {1'b0, div_reg[k].s_div};
            s_ge    = s_shift >= {1'b0, div_reg[k].s_div};
            if (k < CHANNEL_BITS)
            begin
                div_next[k+1].s_rem = s_ge ? s_sub[CHANNEL_BITS-1:0]
                                           : s_shift[CHANNEL_BITS-1:0];
                div_next[k+1].s_low = {div_reg[k].s_low[CHANNEL_BITS-2:0], 1'b0};
                div_next[k+1].s_quo = {div_reg[k].s_quo[CHANNEL_BITS-2:0], s_ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
                div_valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg  <= pixel_valid;
            div_valid_reg[0] <= front_valid_reg;
            for (int i = 1; i <= DIV_STEPS; i++)
                div_valid_reg[i] <= div_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg  <= front_next;
            div_reg[0] <= div_first_next;
            for (int i = 1; i <= DIV_STEPS; i++)
                div_reg[i] <= div_next[i];
        end
    end

    assign hsv_valid      = div_valid_reg[DIV_STEPS];
    assign hsv.hue        = div_reg[DIV_STEPS].h_quo;
    assign hsv.saturation = div_reg[DIV_STEPS].s_quo;
    assign hsv.brightness = div_reg[DIV_STEPS].bright;

endmodule

[sim/rgb_to_hsv_converter_unit_test.sv]
module rgb_to_hsv_converter_unit_test;

    import rgb2hsv_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int CMAX           = (1 << CHANNEL_BITS) - 1;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   pixel_valid = 1'b0;
    logic   pixel_ready;
    pixel_t pixel       = '0;
    logic   hsv_valid;
    logic   hsv_ready   = 1'b0;
    hsv_t   hsv;

    hsv_t hsv_expected[$];
    int   mismatches    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_request  = 0;

    rgb_to_hsv_converter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel      (pixel),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hsv        (hsv)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic hsv_t compute_hsv(input pixel_t p);
        int          r;
        int          g;
        int          b;
        int          hi;
        int          lo;
        int          delta;
        int          num;
        int          sat;
        logic [63:0] quot;
        max_sel_t    sel;
        hsv_t        res;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        hi = r;
        sel = MAX_RED;
        // strict compares keep the red-then-green tie order
        if (g > hi)
        begin
            hi = g;
            sel = MAX_GREEN;
        end
        if (b > hi)
        begin
            hi = b;
            sel = MAX_BLUE;
        end
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        sat = (hi != 0) ? (delta * CMAX) / hi : 0;
        quot = '0;
        if (delta != 0)
        begin
            case (sel)
                MAX_RED:   num = (g - b) + ((g < b) ? 6 * delta : 0);
                MAX_GREEN: num = 2 * delta + (b - r);
                default:   num = 4 * delta + (r - g);
            endcase
            if (num < 0) num = 0;
            quot = (64'(num) << HUE_BITS) / 64'(6 * delta);
        end
        res.hue        = quot[HUE_BITS-1:0];
        res.saturation = CHANNEL_BITS'(sat);
        res.brightness = CHANNEL_BITS'(hi);
        return res;
    endfunction

    function automatic pixel_t rgb(input int r, input int g, input int b);
        pixel_t p;
        p.red   = CHANNEL_BITS'(r);
        p.green = CHANNEL_BITS'(g);
        p.blue  = CHANNEL_BITS'(b);
        return p;
    endfunction

    // mostly uniform, with grays, tied maxima and dim pixels mixed in
    function automatic pixel_t random_pixel();
        int     top;
        int     other;
        pixel_t p;
        p = rgb($urandom_range(CMAX), $urandom_range(CMAX), $urandom_range(CMAX));
        case ($urandom_range(9))
            0:
            begin
                top = $urandom_range(CMAX);
                p = rgb(top, top, top);
            end
            1:
            begin
                top = $urandom_range(CMAX);
                other = $urandom_range(top);
                case ($urandom_range(2))
                    0:       p = rgb(top, top, other);
                    1:       p = rgb(top, other, top);
                    default: p = rgb(other, top, top);
                endcase
            end
            2: p = rgb($urandom_range(15), $urandom_range(15), $urandom_range(15));
            default: ;
        endcase
        return p;
    endfunction

    // valid stays high after the transfer; it is only lowered while idling or by wait_drained
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
    endtask

    // one edge first so the last transfer is already queued
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (hsv_expected.size() != 0) @(posedge clk);
    endtask

    // transfers are sampled before the edge updates anything
    always @(posedge clk)
    begin
        hsv_t exp;
        if (rst_n && pixel_valid && pixel_ready)
            hsv_expected.push_back(compute_hsv(pixel));
        if (rst_n && hsv_valid && hsv_ready)
        begin
            if (hsv_expected.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: hue %0d sat %0d val %0d",
                             hsv.hue, hsv.saturation, hsv.brightness);
                mismatches++;
            end
            else
            begin
                exp = hsv_expected.pop_front();
                if (hsv.hue !== exp.hue || hsv.saturation !== exp.saturation ||
                    hsv.brightness !== exp.brightness)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected hue %0d sat %0d val %0d,",
                                 exp.hue, exp.saturation, exp.brightness,
                                 " got hue %0d sat %0d val %0d",
                                 hsv.hue, hsv.saturation, hsv.brightness);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            hsv_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hsv_ready <= 1'b0;
            hold_left--;
        end
        else
            hsv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic test_directed();
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(CMAX, CMAX, CMAX));
        send_pixel(rgb(CMAX, 0, 0));
        send_pixel(rgb(0, CMAX, 0));
        send_pixel(rgb(0, 0, CMAX));
        send_pixel(rgb(CMAX, CMAX, 0));
        send_pixel(rgb(0, CMAX, CMAX));
        send_pixel(rgb(CMAX, 0, CMAX));
        send_pixel(rgb(CMAX, 0, 1));
        send_pixel(rgb(CMAX, 1, 0));
        send_pixel(rgb(1, 0, 0));
        send_pixel(rgb(0, 1, 0));
        send_pixel(rgb(0, 0, 1));
        send_pixel(rgb(1234, 1234, 1234));
        send_pixel(rgb(1, 1, 1));
        send_pixel(rgb(CMAX, CMAX - 1, CMAX - 2));
        send_pixel(rgb(CMAX - 2, CMAX - 1, CMAX));
        send_pixel(rgb(CMAX - 1, CMAX, CMAX - 2));
        send_pixel(rgb(12'hAAA, 12'h555, 12'h000));
        send_pixel(rgb(12'h555, 12'hAAA, 12'hFFF));
        send_pixel(rgb(2048, 2048, 2047));
        send_pixel(rgb(100, CMAX, CMAX));
        send_pixel(rgb(CMAX, 1, CMAX));
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pixel(random_pixel());
        wait_drained();
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (80) send_pixel(random_pixel());
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(34, 85, 420);
        test_random(85, 34, 420);
        test_random(0, 0, 420);
        test_backpressure();
        repeat (DIV_STEPS + 10) @(posedge clk);
        if (mismatches == 0 && hsv_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
